### design/rats_pkg.sv
// Shared types for the range-assign total-sum block.
// Holds the controller state encoding and the command and status words.
// No dependencies.
package rats_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_VISIT,
		ST_TAG,
		ST_PUSH2,
		ST_DESC,
		ST_RET,
		ST_CMB1,
		ST_CMB2
	} rats_state_t;

	typedef struct packed {
		logic accept;
		logic wr_cover;
		logic rd_tag;
		logic push_lc;
		logic push_rc;
		logic desc;
		logic finish;
		logic ret_right;
		logic ret_pop;
		logic cmb_cap;
		logic cmb_wr;
	} rats_cmd_t;

	typedef struct packed {
		logic walk;
		logic covered;
		logic tag_nz;
		logic sp_zero;
		logic ret_right;
		logic slot_free;
	} rats_stat_t;

endpackage

### design/rats_in_if.sv
// Input word channel of the range-assign total-sum block.
// Carries valid, ready and the item fields. No dependencies.
interface rats_in_if #(
	parameter int POS_W = 11,
	parameter int VALUE_W = 8
);
	logic               valid;
	logic               ready;
	logic               func;
	logic [POS_W-1:0]   range_low;
	logic [POS_W-1:0]   range_high;
	logic [VALUE_W-1:0] value;

	modport source (output valid, func, range_low, range_high, value, input ready);
	modport sink (input valid, func, range_low, range_high, value, output ready);
endinterface

### design/rats_out_if.sv
// Result word channel of the range-assign total-sum block.
// Carries valid, ready and the result fields. No dependencies.
interface rats_out_if #(
	parameter int SUM_W = 18
);
	logic             valid;
	logic             ready;
	logic [SUM_W-1:0] total_value;
	logic             range_error;

	modport source (output valid, total_value, range_error, input ready);
	modport sink (input valid, total_value, range_error, output ready);
endinterface

### design/rats_cfg_if.sv
// Configuration write channel of the range-assign total-sum block.
// Carries valid, ready and the leaf count word. No dependencies.
interface rats_cfg_if #(
	parameter int POS_W = 11
);
	logic             valid;
	logic             ready;
	logic [POS_W-1:0] leaf_count;

	modport source (output valid, leaf_count, input ready);
	modport sink (input valid, leaf_count, output ready);
endinterface

### design/range_assign_total_sum_unit.sv
// Top level of the range-assign total-sum block.
// Instantiates rats_ctrl and rats_dp; uses rats_pkg and the rats channel interfaces.
//
// The block keeps a lazy segment tree over leaf_count positions and returns
// the total of all positions after each word. A re-initialize word or a
// rejected range gives its result straight from the idle state, with no
// tree walk. A range assignment walks the tree with one read and one write
// port on the node memories, writing a covered node and descending into a
// partly covered one. Writing leaf_count also resets every position to one
// and takes effect at once; write it only while no word is in flight.
// There is no clearing pass after reset.
module range_assign_total_sum_unit #(
	parameter int MAX_LEAVES = 1024,
	parameter int VALUE_BITS = 8
) (
	input logic  clk,
	input logic  arst_n,
	rats_in_if.sink     item,
	rats_out_if.source  result,
	rats_cfg_if.sink    cfg
);
	import rats_pkg::*;

	localparam int POS_W = $clog2(MAX_LEAVES + 1);
	localparam int SUM_W = $clog2(64'(MAX_LEAVES) * ((64'(1) << VALUE_BITS) - 1) + 1);

	rats_cmd_t  cmd;
	rats_stat_t stat;

	assign cfg.ready = 1'b1;

	rats_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rats_dp #(
		.MAX_LEAVES (MAX_LEAVES),
		.VALUE_BITS (VALUE_BITS),
		.POS_W      (POS_W),
		.SUM_W      (SUM_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_func   (item.func),
		.in_low    (item.range_low),
		.in_high   (item.range_high),
		.in_value  (item.value),
		.cfg_we    (cfg.valid),
		.cfg_leaf  (cfg.leaf_count),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_total (result.total_value),
		.out_error (result.range_error)
	);

endmodule

### design/rats_ctrl.sv
// Controller state machine of the range-assign total-sum block.
// Sequences the tree walk through commands to the datapath; uses rats_pkg.
module rats_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rats_pkg::rats_stat_t stat,
	output rats_pkg::rats_cmd_t  cmd
);
	import rats_pkg::*;

	rats_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && stat.slot_free && stat.walk) state_d = ST_VISIT;
			end
			ST_VISIT: state_d = stat.covered ? ST_RET : ST_TAG;
			ST_TAG:   state_d = stat.tag_nz ? ST_PUSH2 : ST_DESC;
			ST_PUSH2: state_d = ST_DESC;
			ST_DESC:  state_d = ST_VISIT;
			ST_RET: begin
				if (stat.sp_zero) begin
					if (stat.slot_free) state_d = ST_IDLE;
				end else if (stat.ret_right) begin
					state_d = ST_VISIT;
				end else begin
					state_d = ST_CMB1;
				end
			end
			ST_CMB1: state_d = ST_CMB2;
			ST_CMB2: state_d = ST_RET;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = stat.slot_free;
				cmd.accept = in_valid && stat.slot_free;
			end
			ST_VISIT: begin
				cmd.wr_cover = stat.covered;
				cmd.rd_tag = !stat.covered;
			end
			ST_TAG:   cmd.push_lc = stat.tag_nz;
			ST_PUSH2: cmd.push_rc = 1'b1;
			ST_DESC:  cmd.desc = 1'b1;
			ST_RET: begin
				if (stat.sp_zero) begin
					cmd.finish = stat.slot_free;
				end else if (stat.ret_right) begin
					cmd.ret_right = 1'b1;
				end else begin
					cmd.ret_pop = 1'b1;
				end
			end
			ST_CMB1: cmd.cmb_cap = 1'b1;
			ST_CMB2: cmd.cmb_wr = 1'b1;
			default: cmd = '0;
		endcase
	end

endmodule

### design/rats_dp.sv
// Datapath of the range-assign total-sum block: node memories, root registers,
// walk stack, multiplier and result register. Uses rats_pkg.
module rats_dp #(
	parameter int MAX_LEAVES = 1024,
	parameter int VALUE_BITS = 8,
	parameter int POS_W = 11,
	parameter int SUM_W = 18
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rats_pkg::rats_cmd_t   cmd,
	output rats_pkg::rats_stat_t  stat,
	input  logic                  in_func,
	input  logic [POS_W-1:0]      in_low,
	input  logic [POS_W-1:0]      in_high,
	input  logic [VALUE_BITS-1:0] in_value,
	input  logic                  cfg_we,
	input  logic [POS_W-1:0]      cfg_leaf,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [SUM_W-1:0]      out_total,
	output logic                  out_error
);
	import rats_pkg::*;

	localparam int NODES = 2 * MAX_LEAVES;
	localparam int IDX_W = $clog2(NODES);
	localparam int DEPTH = $clog2(MAX_LEAVES) + 1;
	localparam int SP_W = $clog2(DEPTH + 1);
	localparam int STK_W = $clog2(DEPTH);
	localparam int PROD_W = VALUE_BITS + POS_W;

	logic [SUM_W-1:0]      sum_mem [NODES];
	logic [VALUE_BITS-1:0] tag_mem [NODES];
	logic [SUM_W-1:0]      sum_rd_q;
	logic [VALUE_BITS-1:0] tag_rd_q;

	logic [POS_W-1:0]      leaf_q;
	logic [SUM_W-1:0]      root_sum_q;
	logic [VALUE_BITS-1:0] root_tag_q;

	logic [POS_W-1:0]      lo_q, hi_q, l_q, r_q;
	logic [VALUE_BITS-1:0] val_q, tag_q;
	logic [IDX_W-1:0]      idx_q;
	logic [SUM_W-1:0]      a_q;
	logic [SP_W-1:0]       sp_q;

	logic [IDX_W-1:0] stk_idx [DEPTH];
	logic [POS_W-1:0] stk_l [DEPTH];
	logic [POS_W-1:0] stk_r [DEPTH];
	logic             stk_ph [DEPTH];

	logic [POS_W:0]   lr, tlr;
	logic [POS_W-1:0] m, len_left, len_right, len_all;
	logic [IDX_W-1:0] lc, rc;
	logic [SP_W-1:0]  sp_m1;
	logic [STK_W-1:0] top, wtop;
	logic [POS_W-1:0] tm, tlen;
	logic [IDX_W-1:0] tlc, trc;
	logic [VALUE_BITS-1:0] cur_tag;
	logic             bad;

	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	logic [SUM_W-1:0]      wr_sum;
	logic [VALUE_BITS-1:0] wr_tag;
	logic [VALUE_BITS-1:0] mul_a;
	logic [POS_W-1:0]      mul_b;
	logic [PROD_W-1:0]     prod;
	logic [IDX_W-1:0]      rd_addr;
	logic [POS_W-1:0]      cfg_clamped;

	assign lr = {1'b0, l_q} + {1'b0, r_q};
	assign m = lr[POS_W:1];
	assign len_left = m - l_q + POS_W'(1);
	assign len_right = r_q - m;
	assign len_all = r_q - l_q + POS_W'(1);
	assign lc = idx_q + IDX_W'(1);
	assign rc = idx_q + IDX_W'({len_left, 1'b0});

	assign sp_m1 = sp_q - SP_W'(1);
	assign top = sp_m1[STK_W-1:0];
	assign wtop = sp_q[STK_W-1:0];
	assign tlr = {1'b0, stk_l[top]} + {1'b0, stk_r[top]};
	assign tm = tlr[POS_W:1];
	assign tlen = tm - stk_l[top] + POS_W'(1);
	assign tlc = stk_idx[top] + IDX_W'(1);
	assign trc = stk_idx[top] + IDX_W'({tlen, 1'b0});

	assign cur_tag = (idx_q == '0) ? root_tag_q : tag_rd_q;
	assign bad = (in_low == '0) || (in_high < in_low) || (in_high > leaf_q)
		|| (in_value == '0);

	always_comb begin
		stat.walk = in_func && !bad;
		stat.covered = (lo_q <= l_q) && (r_q <= hi_q);
		stat.tag_nz = cur_tag != '0;
		stat.sp_zero = sp_q == '0;
		stat.ret_right = stk_ph[top] && (hi_q > tm);
		stat.slot_free = !out_valid || out_ready;
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = idx_q;
		wr_tag = val_q;
		mul_a = val_q;
		mul_b = len_all;
		if (cmd.wr_cover) begin
			wr_en = 1'b1;
		end else if (cmd.push_lc) begin
			wr_en = 1'b1;
			wr_addr = lc;
			wr_tag = cur_tag;
			mul_a = cur_tag;
			mul_b = len_left;
		end else if (cmd.push_rc) begin
			wr_en = 1'b1;
			wr_addr = rc;
			wr_tag = tag_q;
			mul_a = tag_q;
			mul_b = len_right;
		end else if (cmd.cmb_wr) begin
			wr_en = 1'b1;
			wr_tag = '0;
		end
		prod = PROD_W'(mul_a) * PROD_W'(mul_b);
		wr_sum = cmd.cmb_wr ? a_q + sum_rd_q : prod[SUM_W-1:0];
	end

	always_comb begin
		rd_addr = idx_q;
		if (cmd.ret_pop) begin
			rd_addr = tlc;
		end else if (cmd.cmb_cap) begin
			rd_addr = rc;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && wr_addr != '0) begin
			sum_mem[wr_addr] <= wr_sum;
			tag_mem[wr_addr] <= wr_tag;
		end
		sum_rd_q <= sum_mem[rd_addr];
		if (cmd.rd_tag) begin
			tag_rd_q <= tag_mem[rd_addr];
		end
	end

	always_comb begin
		cfg_clamped = cfg_leaf;
		if (cfg_leaf == '0) begin
			cfg_clamped = POS_W'(1);
		end else if (cfg_leaf > POS_W'(MAX_LEAVES)) begin
			cfg_clamped = POS_W'(MAX_LEAVES);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaf_q <= POS_W'(MAX_LEAVES);
			root_sum_q <= SUM_W'(MAX_LEAVES);
			root_tag_q <= VALUE_BITS'(1);
			out_valid <= 1'b0;
			sp_q <= '0;
		end else begin
			if (cfg_we) begin
				leaf_q <= cfg_clamped;
				root_sum_q <= SUM_W'(cfg_clamped);
				root_tag_q <= VALUE_BITS'(1);
			end else if (cmd.accept && !in_func) begin
				root_sum_q <= SUM_W'(leaf_q);
				root_tag_q <= VALUE_BITS'(1);
			end else if (wr_en && wr_addr == '0) begin
				root_sum_q <= wr_sum;
				root_tag_q <= wr_tag;
			end
			if (cmd.finish || (cmd.accept && !(in_func && !bad))) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (cmd.accept) begin
				sp_q <= '0;
			end else if (cmd.desc) begin
				sp_q <= sp_q + SP_W'(1);
			end else if (cmd.ret_pop) begin
				sp_q <= sp_m1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			lo_q <= in_low;
			hi_q <= in_high;
			val_q <= in_value;
			idx_q <= '0;
			l_q <= POS_W'(1);
			r_q <= leaf_q;
			out_total <= in_func ? root_sum_q : SUM_W'(leaf_q);
			out_error <= in_func && bad;
		end
		if (cmd.finish) begin
			out_total <= root_sum_q;
			out_error <= 1'b0;
		end
		if (cmd.push_lc) begin
			tag_q <= cur_tag;
		end
		if (cmd.desc) begin
			stk_idx[wtop] <= idx_q;
			stk_l[wtop] <= l_q;
			stk_r[wtop] <= r_q;
			stk_ph[wtop] <= lo_q <= m;
			if (lo_q <= m) begin
				idx_q <= lc;
				r_q <= m;
			end else begin
				idx_q <= rc;
				l_q <= m + POS_W'(1);
			end
		end
		if (cmd.ret_right) begin
			stk_ph[top] <= 1'b0;
			idx_q <= trc;
			l_q <= tm + POS_W'(1);
			r_q <= stk_r[top];
		end
		if (cmd.ret_pop) begin
			idx_q <= stk_idx[top];
			l_q <= stk_l[top];
			r_q <= stk_r[top];
		end
		if (cmd.cmb_cap) begin
			a_q <= sum_rd_q;
		end
	end

endmodule

### bench/tb_top.sv
// Testbench for the range-assign total-sum block: directed and random words
// checked against an in-bench lazy segment tree predictor.
// Depends on the rats channel interfaces and the range_assign_total_sum_unit top level.
module tb_top;

	localparam int MAX_LEAVES = 1024;
	localparam int NODES = 2 * MAX_LEAVES;
	localparam logic FUNC_INIT = 1'b0;
	localparam logic FUNC_ASSIGN = 1'b1;
	localparam int CFG_LEAF_COUNT = 0;

	typedef struct packed {
		logic [17:0] total_value;
		logic        range_error;
	} sum_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors = 0;
	bit   calm = 1'b0;

	rats_in_if  #(.POS_W(11), .VALUE_W(8)) item ();
	rats_out_if #(.SUM_W(18)) result ();
	rats_cfg_if #(.POS_W(11)) cfg ();

	range_assign_total_sum_unit #(.MAX_LEAVES(MAX_LEAVES), .VALUE_BITS(8)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item.sink),
		.result(result.source),
		.cfg(cfg.sink)
	);

	always #1 clk = ~clk;

	longint unsigned tree_sum[NODES];
	int unsigned     tree_tag[NODES];
	int unsigned     leaves;
	sum_result_t     pending_totals[$];

	initial begin
		item.valid = 1'b0;
		item.func = FUNC_INIT;
		item.range_low = '0;
		item.range_high = '0;
		item.value = '0;
		cfg.valid = 1'b0;
		cfg.leaf_count = '0;
		result.ready = 1'b0;
	end

	function automatic void tree_clear();
		for (int i = 0; i < NODES; i++) begin
			tree_sum[i] = 0;
			tree_tag[i] = 0;
		end
		tree_sum[0] = leaves;
		tree_tag[0] = 1;
	endfunction

	function automatic void tree_push(int unsigned idx, int unsigned l, int unsigned r);
		int unsigned m, lc, rc, t;
		m = (l + r) >> 1;
		lc = idx + 1;
		rc = idx + 2 * (m - l + 1);
		t = tree_tag[idx];
		if (t == 0 || rc >= NODES)
			return;
		tree_tag[lc] = t;
		tree_tag[rc] = t;
		tree_sum[lc] = longint'(t) * (m - l + 1);
		tree_sum[rc] = longint'(t) * (r - m);
		tree_tag[idx] = 0;
	endfunction

	function automatic void tree_assign(int unsigned lo, int unsigned hi, int unsigned v,
			int unsigned idx, int unsigned l, int unsigned r);
		int unsigned m, lc, rc;
		if (idx >= NODES)
			return;
		if (lo <= l && r <= hi) begin
			tree_tag[idx] = v;
			tree_sum[idx] = longint'(v) * (r - l + 1);
			return;
		end
		tree_push(idx, l, r);
		m = (l + r) >> 1;
		lc = idx + 1;
		rc = idx + 2 * (m - l + 1);
		if (rc >= NODES)
			return;
		if (lo <= m)
			tree_assign(lo, hi, v, lc, l, m);
		if (hi > m)
			tree_assign(lo, hi, v, rc, m + 1, r);
		tree_sum[idx] = tree_sum[lc] + tree_sum[rc];
	endfunction

	function automatic sum_result_t predict_total(logic func, int unsigned lo,
			int unsigned hi, int unsigned v);
		sum_result_t res;
		res.range_error = 1'b0;
		if (func == FUNC_INIT)
			tree_clear();
		else if (lo == 0 || hi < lo || hi > leaves || v == 0)
			res.range_error = 1'b1;
		else
			tree_assign(lo, hi, v, 0, 1, leaves);
		res.total_value = tree_sum[0][17:0];
		return res;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("mismatch on %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	// The input stays valid between back-to-back words; it drops for a gap and while draining.
	task automatic idle_burst();
		if (!calm && $urandom_range(0, 3) == 0) begin
			item.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	task automatic send_word(logic func, int unsigned lo, int unsigned hi, int unsigned v);
		idle_burst();
		pending_totals.push_back(predict_total(func, lo, hi, v));
		item.valid <= 1'b1;
		item.func <= func;
		item.range_low <= lo[10:0];
		item.range_high <= hi[10:0];
		item.value <= v[7:0];
		@(posedge clk);
		while (!item.ready)
			@(posedge clk);
	endtask

	task automatic drain();
		item.valid <= 1'b0;
		while (pending_totals.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_leaf_count(int unsigned n);
		int unsigned v;
		drain();
		v = n & 11'h7FF;
		if (v == 0)
			v = 1;
		if (v > MAX_LEAVES)
			v = MAX_LEAVES;
		cfg.valid <= 1'b1;
		cfg.leaf_count <= n[10:0];
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		leaves = v;
		tree_clear();
	endtask

	// Sink side: random stalls, then check each word against the oldest expectation.
	always @(posedge clk) begin
		sum_result_t want;
		if (arst_n && result.valid && result.ready) begin
			if (pending_totals.size() == 0) begin
				$display("unexpected result word");
				errors++;
			end else begin
				want = pending_totals.pop_front();
				if (result.total_value !== want.total_value)
					report_mismatch("total_value", result.total_value, want.total_value);
				if (result.range_error !== want.range_error)
					report_mismatch("range_error", result.range_error, want.range_error);
			end
		end
	end

	initial begin
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				stall--;
				result.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 13) - 1;
				result.ready <= 1'b0;
			end else
				result.ready <= 1'b1;
		end
	end

	task automatic random_assign(int unsigned n);
		int unsigned lo, hi;
		lo = $urandom_range(1, n);
		hi = $urandom_range(lo, n);
		send_word(FUNC_ASSIGN, lo, hi, $urandom_range(1, 255));
	endtask

	task automatic test_directed();
		send_word(FUNC_ASSIGN, 1, 1024, 255);
		send_word(FUNC_ASSIGN, 1, 1, 1);
		send_word(FUNC_ASSIGN, 1024, 1024, 128);
		send_word(FUNC_ASSIGN, 300, 700, 85);
		send_word(FUNC_ASSIGN, 0, 5, 9);
		send_word(FUNC_ASSIGN, 9, 8, 9);
		send_word(FUNC_ASSIGN, 1, 1025, 9);
		send_word(FUNC_ASSIGN, 2047, 2047, 9);
		send_word(FUNC_ASSIGN, 5, 10, 0);
		send_word(FUNC_INIT, 2047, 0, 255);
		send_word(FUNC_ASSIGN, 512, 513, 170);
		send_word(FUNC_INIT, 0, 2047, 0);
	endtask

	task automatic test_leaf_counts();
		int unsigned sizes[6] = '{1, 2, 3, 0, 2047, 37};
		foreach (sizes[i]) begin
			write_leaf_count(sizes[i]);
			send_word(FUNC_ASSIGN, 1, leaves, 200);
			send_word(FUNC_ASSIGN, 1, leaves + 1, 3);
			repeat (8) random_assign(leaves);
		end
	endtask

	task automatic test_random(int unsigned count, bit small_tree);
		int unsigned r;
		for (int k = 0; k < count; k++) begin
			if (small_tree && k % 150 == 0)
				write_leaf_count($urandom_range(1, 64));
			r = $urandom_range(0, 99);
			if (r < 80)
				random_assign(leaves);
			else if (r < 85)
				send_word(FUNC_INIT, $urandom_range(0, 2047), $urandom_range(0, 2047),
					$urandom_range(0, 255));
			else
				send_word(FUNC_ASSIGN, $urandom_range(0, 2047), $urandom_range(0, 2047),
					$urandom_range(0, 255));
		end
	endtask

	initial begin
		leaves = MAX_LEAVES;
		tree_clear();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_leaf_counts();
		test_random(680, 1'b1);
		write_leaf_count(MAX_LEAVES);
		test_random(500, 1'b0);
		calm = 1'b1;
		test_random(200, 1'b0);
		drain();
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#4000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

### files.f
design/rats_pkg.sv
design/rats_in_if.sv
design/rats_out_if.sv
design/rats_cfg_if.sv
design/rats_ctrl.sv
design/rats_dp.sv
design/range_assign_total_sum_unit.sv
bench/tb_top.sv
